// ===== hdl/nh128_pkg.sv =====
`default_nettype none

package nh128_pkg;

    // hash constants
    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
    localparam logic [63:0] SEED_MUL  = 64'h9E3779B185EBCA87;
    localparam logic [63:0] MIX_ADD   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2  = 64'h94D049BB133111EB;

    // input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       no_byte;
    } item_t;

    // result transfer payload
    typedef struct packed {
        logic [63:0] hash_high;
        logic [63:0] hash_low;
        logic        too_long;
    } result_t;

    // request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // x * FNV_PRIME mod 2^64, prime is 2^40 + 0x1B3
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        fnv_mul = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nh128_ram.sv =====
`default_nettype none

module nh128_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nh128_mul.sv =====
`default_nettype none

module nh128_mul (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nh128_pkg::mul_req_t  req,
    output logic                      done,
    output logic [63:0]               prod
);

    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_LH = 2'd1;
    localparam logic [1:0] PP_HL = 2'd2;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] pp;
    logic [63:0] acc_next;

    // pick one 32x32 partial product per cycle, high-high term falls off
    always_comb
    begin
        unique case (step_reg)
            PP_LL:
            begin
                x = a_reg[31:0];
                y = b_reg[31:0];
            end
            PP_LH:
            begin
                x = a_reg[31:0];
                y = b_reg[63:32];
            end
            PP_HL:
            begin
                x = a_reg[63:32];
                y = b_reg[31:0];
            end
            default:
            begin
                x = '0;
                y = '0;
            end
        endcase
        pp = 64'(x) * 64'(y);
        acc_next = (step_reg == PP_LL) ? pp : acc_reg + {pp[31:0], 32'd0};
    end

    // operand capture and accumulation
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= PP_LL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (step_reg == PP_HL)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= PP_LL;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= PP_LL;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/name_hash_128.sv =====
`default_nettype none

// 128-bit name hash. Send the bytes of a name one per transfer, last_byte on
// the final one; an empty name is a single transfer with no_byte and last_byte
// set, and a no_byte transfer without last_byte is ignored. Each byte that fits
// is folded into a forward FNV-1a hash and written to the byte memory. After the
// last byte the block stalls its input through a seed multiply, a reverse
// FNV-1a pass out of the memory's read port, and three splitmix64 finalizers
// on a shared 64-bit multiplier that sums three 32x32 partial products, one a
// cycle, and then loads the output register once it is free. A name longer
// than MAX_NAME_BYTES gives too_long with a zero hash and skips the hashing
// steps. No clearing pass is needed after reset.
module name_hash_128 #(
    parameter int MAX_NAME_BYTES = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire nh128_pkg::item_t    item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output nh128_pkg::result_t       result
);

    localparam int AW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
    localparam int CW = $clog2(MAX_NAME_BYTES + 1);

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_SEED    = 3'd1;
    localparam logic [2:0] ST_SEED_W  = 3'd2;
    localparam logic [2:0] ST_REV     = 3'd3;
    localparam logic [2:0] ST_MIX     = 3'd4;
    localparam logic [2:0] ST_MIX_W1  = 3'd5;
    localparam logic [2:0] ST_MIX_W2  = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    localparam logic [1:0] MIX_R0 = 2'd0;
    localparam logic [1:0] MIX_F  = 2'd1;
    localparam logic [1:0] MIX_R1 = 2'd2;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [63:0]   fwd_reg, fwd_next;
    logic [63:0]   rev_reg, rev_next;
    logic          ovf_reg, ovf_next;
    logic          pend_reg, pend_next;
    logic [1:0]    mix_reg, mix_next;
    logic          out_valid_reg, out_valid_next;
    nh128_pkg::result_t out_reg, out_next;

    logic                  item_fire;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [7:0]            mem_rdata;
    nh128_pkg::mul_req_t   mul_req;
    logic                  mul_done;
    logic [63:0]           mul_prod;
    logic [63:0]           mix_in;
    logic [63:0]           mix_pre;
    logic [63:0]           mix_mid;
    logic [63:0]           mix_out;

    assign item_fire = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_LOAD);

    // byte memory, write on load, read backwards in the reverse pass
    assign mem_we = item_fire && !item.no_byte && (count_reg < CW'(MAX_NAME_BYTES));

    nh128_ram #(
        .WIDTH(8),
        .DEPTH(MAX_NAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.data_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    nh128_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // finalizer input crossing the two halves
    always_comb
    begin
        unique case (mix_reg)
            MIX_R0:  mix_in = rev_reg ^ (fwd_reg << 1);
            MIX_F:   mix_in = fwd_reg + (rev_reg << 32);
            MIX_R1:  mix_in = rev_reg + (fwd_reg << 24);
            default: mix_in = rev_reg;
        endcase
        mix_pre = mix_in + nh128_pkg::MIX_ADD;
        mix_pre = mix_pre ^ (mix_pre >> 30);
        mix_mid = mul_prod ^ (mul_prod >> 27);
        mix_out = mul_prod ^ (mul_prod >> 31);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fwd_next       = fwd_reg;
        rev_next       = rev_reg;
        ovf_next       = ovf_reg;
        pend_next      = 1'b0;
        mix_next       = mix_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        mem_re         = 1'b0;
        mem_raddr      = count_reg[AW-1:0] - AW'(1);
        mul_req.start  = 1'b0;
        mul_req.a      = fwd_reg;
        mul_req.b      = nh128_pkg::SEED_MUL;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_fire)
                begin
                    if (!item.no_byte)
                    begin
                        if (count_reg < CW'(MAX_NAME_BYTES))
                        begin
                            count_next = count_reg + CW'(1);
                            fwd_next = nh128_pkg::fnv_mul(fwd_reg ^ 64'(item.data_byte));
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (item.last_byte)
                    begin
                        state_next = ovf_next ? ST_DONE : ST_SEED;
                    end
                end
            end
            ST_SEED:
            begin
                mul_req.start = 1'b1;
                state_next = ST_SEED_W;
            end
            ST_SEED_W:
            begin
                if (mul_done)
                begin
                    rev_next = nh128_pkg::FNV_PRIME ^ mul_prod;
                    state_next = ST_REV;
                end
            end
            ST_REV:
            begin
                // one read issued and one byte folded per cycle
                if (count_reg != '0)
                begin
                    mem_re = 1'b1;
                    count_next = count_reg - CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    rev_next = nh128_pkg::fnv_mul(rev_reg ^ 64'(mem_rdata));
                end
                if (count_reg == '0 && !pend_reg)
                begin
                    mix_next = MIX_R0;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                mul_req.start = 1'b1;
                mul_req.a = mix_pre;
                mul_req.b = nh128_pkg::MIX_MUL1;
                state_next = ST_MIX_W1;
            end
            ST_MIX_W1:
            begin
                mul_req.a = mix_mid;
                mul_req.b = nh128_pkg::MIX_MUL2;
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    state_next = ST_MIX_W2;
                end
            end
            ST_MIX_W2:
            begin
                if (mul_done)
                begin
                    if (mix_reg == MIX_F)
                    begin
                        fwd_next = mix_out;
                    end
                    else
                    begin
                        rev_next = mix_out;
                    end
                    if (mix_reg == MIX_R1)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mix_next = mix_reg + 2'd1;
                        state_next = ST_MIX;
                    end
                end
            end
            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next     = 1'b1;
                    out_next.too_long  = ovf_reg;
                    out_next.hash_high = ovf_reg ? 64'd0 : fwd_reg;
                    out_next.hash_low  = ovf_reg ? 64'd0 : rev_reg;
                    count_next = '0;
                    fwd_next   = nh128_pkg::FNV_BASIS;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            fwd_reg       <= nh128_pkg::FNV_BASIS;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            mix_reg       <= MIX_R0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fwd_reg       <= fwd_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            mix_reg       <= mix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rev_reg <= rev_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== tb/name_hash_128_test.sv =====
`default_nettype none

module name_hash_128_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_CAP    = 256;
    localparam int PHASE_ITEMS = 75;
    localparam int TAIL_CYCLES = NAME_CAP + 40;
    localparam int CYCLE_LIMIT = 400000;

    // hash constants, kept apart from the design's own copies
    localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_MULT   = 64'h00000100000001B3;
    localparam logic [63:0] SEED_MULT  = 64'h9E3779B185EBCA87;
    localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] FOLD_MUL_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] FOLD_MUL_B = 64'h94D049BB133111EB;

    localparam nh128_pkg::result_t NO_PIN      = '0;
    localparam nh128_pkg::result_t TOO_LONG_ID = {64'd0, 64'd0, 1'b1};

    // one row of the directed list, repeated reps times
    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic               none;
        logic [9:0]         reps;
        logic               pinned;
        nh128_pkg::result_t pinned_res;
    } plan_row_t;

    localparam int PLAN_ROWS = 22;

    plan_row_t name_plan [PLAN_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 10'd1,   1'b0, NO_PIN},      // empty name
        '{8'hFF, 1'b0, 1'b1, 10'd1,   1'b0, NO_PIN},      // ignored item
        '{8'h00, 1'b1, 1'b0, 10'd1,   1'b0, NO_PIN},      // one zero byte
        '{8'hFF, 1'b1, 1'b0, 10'd1,   1'b0, NO_PIN},      // one all-ones byte
        '{8'h61, 1'b0, 1'b0, 10'd1,   1'b0, NO_PIN},
        '{8'h5A, 1'b0, 1'b1, 10'd1,   1'b0, NO_PIN},      // ignored mid-name
        '{8'h62, 1'b1, 1'b0, 10'd1,   1'b0, NO_PIN},
        '{8'h80, 1'b0, 1'b0, 10'd1,   1'b0, NO_PIN},
        '{8'h11, 1'b1, 1'b1, 10'd1,   1'b0, NO_PIN},      // end without a byte
        '{8'hA5, 1'b0, 1'b0, 10'd255, 1'b0, NO_PIN},
        '{8'h3C, 1'b1, 1'b0, 10'd1,   1'b0, NO_PIN},      // buffer exactly full
        '{8'h00, 1'b0, 1'b0, 10'd256, 1'b0, NO_PIN},
        '{8'hFF, 1'b1, 1'b0, 10'd1,   1'b1, TOO_LONG_ID}, // overflow on the last byte
        '{8'h55, 1'b0, 1'b0, 10'd256, 1'b0, NO_PIN},
        '{8'h77, 1'b0, 1'b0, 10'd2,   1'b0, NO_PIN},      // overflow mid-name
        '{8'hAA, 1'b0, 1'b1, 10'd1,   1'b0, NO_PIN},
        '{8'h00, 1'b1, 1'b1, 10'd1,   1'b1, TOO_LONG_ID}, // overflowed, end without byte
        '{8'h01, 1'b1, 1'b0, 10'd1,   1'b0, NO_PIN},      // state cleared after overflow
        '{8'hC3, 1'b0, 1'b0, 10'd256, 1'b0, NO_PIN},
        '{8'h00, 1'b1, 1'b1, 10'd1,   1'b0, NO_PIN},      // full buffer, no overflow
        '{8'hFE, 1'b0, 1'b0, 10'd1,   1'b0, NO_PIN},
        '{8'h7F, 1'b1, 1'b0, 10'd1,   1'b0, NO_PIN}
    };

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    nh128_pkg::item_t   item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    nh128_pkg::result_t result;

    // predictor state
    logic [7:0]  name_bytes [$];
    logic [63:0] fwd_hash      = FNV_OFFSET;
    bit          name_overflow = 1'b0;

    nh128_pkg::result_t pending_ids [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int errors       = 0;
    int ids_checked  = 0;
    int names_done   = 0;
    int too_long_cnt = 0;
    int empty_cnt    = 0;
    int name_items   = 0;
    int cycle_count  = 0;

    int idle_mix  [4] = '{0, 59, 0, 12};
    int stall_mix [4] = '{0, 0, 59, 12};

    name_hash_128 #(
        .MAX_NAME_BYTES(NAME_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // splitmix64 finalizer
    function automatic logic [63:0] splitmix_fold(input logic [63:0] v);
        logic [63:0] m;
        m = v + GOLDEN_INC;
        m = (m ^ (m >> 30)) * FOLD_MUL_A;
        m = (m ^ (m >> 27)) * FOLD_MUL_B;
        return m ^ (m >> 31);
    endfunction

    // advance the name state by one transfer; returns 1 when an identifier is due
    function automatic bit predict_name_id(input nh128_pkg::item_t it,
                                           output nh128_pkg::result_t id);
        logic [63:0] f;
        logic [63:0] r;
        int          k;
        id = '0;
        if (!it.no_byte)
        begin
            if (name_bytes.size() < NAME_CAP)
            begin
                name_bytes.push_back(it.data_byte);
                fwd_hash = (fwd_hash ^ {56'd0, it.data_byte}) * FNV_MULT;
            end
            else
                name_overflow = 1'b1;
        end
        if (!it.last_byte)
            return 1'b0;
        names_done++;
        if (name_overflow)
        begin
            id.too_long = 1'b1;
            too_long_cnt++;
        end
        else
        begin
            if (name_bytes.size() == 0)
                empty_cnt++;
            f = fwd_hash;
            r = FNV_MULT ^ (f * SEED_MULT);
            for (k = name_bytes.size() - 1; k >= 0; k--)
                r = (r ^ {56'd0, name_bytes[k]}) * FNV_MULT;
            r = splitmix_fold(r ^ (f << 1));
            f = splitmix_fold(f + (r << 32));
            r = splitmix_fold(r + (f << 24));
            id.hash_high = f;
            id.hash_low  = r;
        end
        name_bytes.delete();
        fwd_hash      = FNV_OFFSET;
        name_overflow = 1'b0;
        return 1'b1;
    endfunction

    // one input transfer, called and returning at a falling edge
    task automatic send_item(input nh128_pkg::item_t it, input bit pinned,
                             input nh128_pkg::result_t pinned_res);
        int                 gap;
        nh128_pkg::result_t id;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        if (predict_name_id(it, id))
            pending_ids.push_back(pinned ? pinned_res : id);
        if (!it.no_byte || it.last_byte)
            name_items++;
        @(negedge clk);
    endtask

    // hold off the sender until every identifier has come back
    task automatic wait_all_ids();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_ids.size() != 0);
    endtask

    // one random name, mostly short, with stray ignored transfers
    task automatic send_random_name();
        int               sel;
        int               len;
        int               k;
        bit               end_bare;
        nh128_pkg::item_t it;
        sel = $urandom_range(99);
        if (sel < 4)
            len = 0;
        else if (sel < 5)
            len = $urandom_range(NAME_CAP - 2, NAME_CAP + 3);
        else if (sel < 20)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(1, 8);
        end_bare = (len == 0) || ($urandom_range(9) == 0);
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(19) == 0)
            begin
                it.data_byte = 8'($urandom_range(255));
                it.last_byte = 1'b0;
                it.no_byte   = 1'b1;
                send_item(it, 1'b0, NO_PIN);
            end
            it.data_byte = 8'($urandom_range(255));
            it.last_byte = (k == len - 1) && !end_bare;
            it.no_byte   = 1'b0;
            send_item(it, 1'b0, NO_PIN);
        end
        if (end_bare)
        begin
            it.data_byte = 8'($urandom_range(255));
            it.last_byte = 1'b1;
            it.no_byte   = 1'b1;
            send_item(it, 1'b0, NO_PIN);
        end
    endtask

    // receiver back-pressure
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // check each identifier transfer against the oldest prediction
    always @(posedge clk)
    begin
        nh128_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_ids.size() == 0)
            begin
                $display("%0t: unexpected transfer high=%h low=%h too_long=%b",
                         $time, result.hash_high, result.hash_low, result.too_long);
                errors++;
            end
            else
            begin
                want = pending_ids.pop_front();
                ids_checked++;
                if (result.hash_high !== want.hash_high)
                begin
                    $display("%0t: hash_high expected %h got %h",
                             $time, want.hash_high, result.hash_high);
                    errors++;
                end
                if (result.hash_low !== want.hash_low)
                begin
                    $display("%0t: hash_low expected %h got %h",
                             $time, want.hash_low, result.hash_low);
                    errors++;
                end
                if (result.too_long !== want.too_long)
                begin
                    $display("%0t: too_long expected %b got %b",
                             $time, want.too_long, result.too_long);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d identifiers outstanding", $time, pending_ids.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int               r;
        int               n;
        int               p;
        nh128_pkg::item_t it;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed list, no idling
        for (r = 0; r < PLAN_ROWS; r++)
        begin
            it.data_byte = name_plan[r].data;
            it.last_byte = name_plan[r].last;
            it.no_byte   = name_plan[r].none;
            for (n = 0; n < name_plan[r].reps; n++)
                send_item(it, name_plan[r].pinned, name_plan[r].pinned_res);
        end
        wait_all_ids();

        // random names under each idling mix
        for (p = 0; p < 4; p++)
        begin
            idle_pct   = idle_mix[p];
            stall_pct  = stall_mix[p];
            name_items = 0;
            while (name_items < PHASE_ITEMS)
            begin
                send_random_name();
                if ($urandom_range(29) == 0)
                    wait_all_ids();
            end
            wait_all_ids();
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d names (%0d empty, %0d too long), %0d identifiers checked",
                 names_done, empty_cnt, too_long_cnt, ids_checked);
        $display("idling mixes: none, sender 59%%, receiver 59%%, both 12%%");
        if (errors == 0 && pending_ids.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/nh128_pkg.sv
hdl/nh128_ram.sv
hdl/nh128_mul.sv
hdl/name_hash_128.sv
tb/name_hash_128_test.sv
